>>> rtl/core/dti_pkg.sv
// dti_pkg: shared sizes, table entry layouts, codes and step result type
// for the decision tree inference block; no dependencies
`default_nettype none

package dti_pkg;

   localparam int MAX_NODES    = 1024;
   localparam int MAX_FEATURES = 64;
   localparam int MAX_STEPS    = 64;

   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int FEAT_AW = $clog2(MAX_FEATURES);
   localparam int STEP_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   localparam int COUNT_W  = 11;
   localparam int FC_W     = 7;
   localparam int CHILD_W  = 11;
   localparam int CLASS_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 11;

   localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(MAX_NODES);
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(MAX_STEPS - 1);

   // request kinds
   localparam logic REQ_NODE_WRITE    = 1'b0;
   localparam logic REQ_FEATURE_WRITE = 1'b1;

   // csr register indexes
   localparam logic CSR_NODE_COUNT    = 1'b0;
   localparam logic CSR_FEATURE_COUNT = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STEP_LIMIT = 2'd2;

   typedef struct packed {
      logic [FEAT_AW-1:0] feature;
      logic [VALUE_W-1:0] threshold;
   } split_type;

   typedef struct packed {
      logic               leaf;
      logic [CHILD_W-1:0] left;
      logic [CHILD_W-1:0] right;
      logic [CLASS_W-1:0] cls;
   } link_type;

   typedef struct packed {
      logic               early_stop;
      logic               go_next;
      logic [NODE_AW-1:0] next_idx;
   } step_type;

endpackage

`default_nettype wire

>>> rtl/core/dti_step.sv
// dti_step: per-node decision of the tree walk (stop test, signed compare,
// child select and range check); depends on dti_pkg
`default_nettype none

module dti_step (
   input  dti_pkg::link_type                    link,
   input  logic signed [dti_pkg::VALUE_W-1:0]   threshold,
   input  logic signed [dti_pkg::VALUE_W-1:0]   sample,
   input  logic        [dti_pkg::COUNT_W-1:0]   node_limit,
   output dti_pkg::step_type                    result
);
   import dti_pkg::*;

   logic               take_left;
   logic [NODE_AW-1:0] next_idx;

   always_comb begin
      take_left = (sample <= threshold);
      next_idx  = take_left ? link.left[NODE_AW-1:0] : link.right[NODE_AW-1:0];

      // leaf or missing child ends the walk on this node
      result.early_stop = link.leaf | link.left[CHILD_W-1] | link.right[CHILD_W-1];
      result.next_idx   = next_idx;
      result.go_next    = ({1'b0, next_idx} < node_limit);
   end

endmodule

`default_nettype wire

>>> rtl/core/decision_tree_inference.sv
// decision_tree_inference: top level with node tables, sample store,
// walk sequencer and result register; depends on dti_pkg and dti_step
`default_nettype none

// result path: node writes and plain feature writes give no result; a last
// feature write starts a walk that reads each node from the node table and,
// unless the walk stops on it, then its feature from the sample store; the
// walk stops at a leaf or missing child, at a child out of range or at the
// step limit, and an empty tree gives its result with no walk
// throughput: one transaction per cycle while idle, one walk at a time, input
// held off while a result waits for the output register
// reset: control, node_count (0) and result valid clear; tables and sample
// store keep their contents and are undefined until written

module decision_tree_inference (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [dti_pkg::NODE_AW-1:0]         req_node_slot,
   input  logic                                req_leaf_mark,
   input  logic [dti_pkg::FEAT_AW-1:0]         req_split_feature,
   input  logic signed [dti_pkg::VALUE_W-1:0]  req_split_threshold,
   input  logic signed [dti_pkg::CHILD_W-1:0]  req_left_child,
   input  logic signed [dti_pkg::CHILD_W-1:0]  req_right_child,
   input  logic [dti_pkg::CLASS_W-1:0]         req_node_class,
   input  logic [dti_pkg::FEAT_AW-1:0]         req_feature_slot,
   input  logic signed [dti_pkg::VALUE_W-1:0]  req_feature_value,
   input  logic                                req_last_feature,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dti_pkg::CLASS_W-1:0]         rsp_predicted_class,
   output logic [dti_pkg::STATUS_W-1:0]        rsp_status,
   // csr write port
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [dti_pkg::CSR_W-1:0]           csr_wdata
);
   import dti_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,   // waiting for a transaction
      ST_NODE = 4'b0010,   // node entry arriving from the tables
      ST_EVAL = 4'b0100,   // sample value arriving, compare and branch
      ST_DONE = 4'b1000    // result waiting for the output register
   } state_type;

   // state storage: node tables and the sample store
   split_type          split_mem  [MAX_NODES];
   link_type           link_mem   [MAX_NODES];
   logic [VALUE_W-1:0] sample_mem [MAX_FEATURES];

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  node_count_ff, node_count_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CLASS_W-1:0]  res_class_ff, res_class_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   split_type           split_rd_ff;
   link_type            link_rd_ff;
   logic [VALUE_W-1:0]  sample_rd_ff;

   logic                req_fire;
   logic                node_we;
   logic                feat_we;
   logic                walk_start;
   logic                node_re;
   logic [NODE_AW-1:0]  node_rd_addr;
   logic                sample_re;
   logic [COUNT_W-1:0]  node_limit;
   logic                rsp_free;
   step_type            step_res;

   // ---------------------------------------------------------------------
   // handshake and request decode
   // ---------------------------------------------------------------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign node_we    = req_fire & (req_type == REQ_NODE_WRITE);
   assign feat_we    = req_fire & (req_type == REQ_FEATURE_WRITE);
   assign walk_start = feat_we & req_last_feature;

   // node counts above the table size act as a full table
   assign node_limit = (node_count_ff > NODE_LIMIT) ? NODE_LIMIT : node_count_ff;

   // output register can take a result this cycle
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   // ---------------------------------------------------------------------
   // node decision logic
   // ---------------------------------------------------------------------
   dti_step u_step (
      .link       (link_rd_ff),
      .threshold  (split_rd_ff.threshold),
      .sample     (sample_rd_ff),
      .node_limit (node_limit),
      .result     (step_res)
   );

   // ---------------------------------------------------------------------
   // walk sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      res_class_in  = res_class_ff;
      res_status_in = res_status_ff;
      node_re       = 1'b0;
      node_rd_addr  = '0;
      sample_re     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (walk_start) begin
               step_in = '0;
               if (node_limit == '0) begin
                  // empty tree, no walk
                  res_class_in  = '0;
                  res_status_in = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  // root entry read; the feature just written is stored before any sample read
                  node_re      = 1'b1;
                  node_rd_addr = '0;
                  state_in     = ST_NODE;
               end
            end
         end
         ST_NODE: begin
            if (step_res.early_stop) begin
               res_class_in  = link_rd_ff.cls;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else begin
               // fetch the feature this node splits on
               sample_re = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!step_res.go_next) begin
               // chosen child is outside the loaded tree
               res_class_in  = link_rd_ff.cls;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else if (step_ff == LAST_STEP) begin
               // step budget used up without reaching a stop
               res_class_in  = '0;
               res_status_in = STATUS_STEP_LIMIT;
               state_in      = ST_DONE;
            end else begin
               step_in      = step_ff + STEP_W'(1);
               node_re      = 1'b1;
               node_rd_addr = step_res.next_idx;
               state_in     = ST_NODE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // output register, loaded from the pending result
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_class_in  = res_class_ff;
         rsp_status_in = res_status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_class = rsp_class_ff;
   assign rsp_status          = rsp_status_ff;

   // ---------------------------------------------------------------------
   // csr: node count is the only register that steers the walk, the
   // feature count write is taken and has no effect
   // ---------------------------------------------------------------------
   always_comb begin
      node_count_in = node_count_ff;
      if (csr_we && (csr_index == CSR_NODE_COUNT)) begin
         node_count_in = csr_wdata[COUNT_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      res_class_ff  <= res_class_in;
      res_status_ff <= res_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ---------------------------------------------------------------------
   // node tables: written by node transactions, read by the walk; a walk
   // never overlaps a node write since requests stall while walking
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (node_we) begin
         split_mem[req_node_slot] <= '{feature:   req_split_feature,
                                       threshold: req_split_threshold};
         link_mem[req_node_slot]  <= '{leaf:  req_leaf_mark,
                                       left:  req_left_child,
                                       right: req_right_child,
                                       cls:   req_node_class};
      end
      if (node_re) begin
         split_rd_ff <= split_mem[node_rd_addr];
         link_rd_ff  <= link_mem[node_rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // sample store: the last feature is written at the accepting edge, the
   // first sample read comes in the cycle after it, so no bypass is needed
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (feat_we) begin
         sample_mem[req_feature_slot] <= req_feature_value;
      end
      if (sample_re) begin
         sample_rd_ff <= sample_mem[split_rd_ff.feature];
      end
   end

endmodule

`default_nettype wire

>>> test/decision_tree_inference_tb.sv
// decision_tree_inference_tb: self-checking bench for the decision tree inference block
// holds its own tree walker, a queue-fed request driver and a response monitor
// depends on dti_pkg and decision_tree_inference
`timescale 1ns / 100ps

module decision_tree_inference_tb;
   import dti_pkg::*;

   // run shape
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int PRELOAD_NODES   = 128;     // node entries loaded before any walk
   localparam int SETTLE_CYCLES   = 2 + 2 * MAX_STEPS + 16;   // longest walk plus margin
   localparam int QUIET_LIMIT     = 20000;
   localparam int HOLD_AT         = 20;      // result count that starts the long stall
   localparam int HOLD_CYCLES     = 300;

   localparam logic [CHILD_W-1:0] CHILD_NONE = '1;
   localparam logic [VALUE_W-1:0] Q_MIN      = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] Q_MAX      = 32'h7FFF_FFFF;

   // one request transaction, all fields at port widths
   typedef struct {
      logic               kind;
      logic [NODE_AW-1:0] node_slot;
      logic               leaf_mark;
      logic [FEAT_AW-1:0] split_feature;
      logic [VALUE_W-1:0] split_threshold;
      logic [CHILD_W-1:0] left_child;
      logic [CHILD_W-1:0] right_child;
      logic [CLASS_W-1:0] node_class;
      logic [FEAT_AW-1:0] feature_slot;
      logic [VALUE_W-1:0] feature_value;
      logic               last_feature;
   } tree_req_t;

   // one classification outcome
   typedef struct packed {
      logic [CLASS_W-1:0]  cls;
      logic [STATUS_W-1:0] status;
   } tree_answer_t;

   // clock, reset and dut inputs, all known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_type = REQ_NODE_WRITE;
   logic [NODE_AW-1:0]  req_node_slot = '0;
   logic                req_leaf_mark = 1'b0;
   logic [FEAT_AW-1:0]  req_split_feature = '0;
   logic [VALUE_W-1:0]  req_split_threshold = '0;
   logic [CHILD_W-1:0]  req_left_child = '0;
   logic [CHILD_W-1:0]  req_right_child = '0;
   logic [CLASS_W-1:0]  req_node_class = '0;
   logic [FEAT_AW-1:0]  req_feature_slot = '0;
   logic [VALUE_W-1:0]  req_feature_value = '0;
   logic                req_last_feature = 1'b0;
   logic                rsp_ready = 1'b0;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_NODE_COUNT;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // dut outputs
   logic                req_ready;
   logic                rsp_valid;
   logic [CLASS_W-1:0]  rsp_predicted_class;
   logic [STATUS_W-1:0] rsp_status;

   // bench-side copy of the tables, sample store and registers
   split_type           tree_split [MAX_NODES];
   link_type            tree_link [MAX_NODES];
   logic [VALUE_W-1:0]  sample_values [MAX_FEATURES];
   logic [COUNT_W-1:0]  node_count_cfg = '0;
   logic [FC_W-1:0]     feature_count_cfg = FC_W'(1);

   tree_req_t           pending_items [$];   // requests waiting to be sent
   tree_answer_t        answers_due [$];     // classifications not yet seen on rsp
   tree_req_t           offer;
   tree_answer_t        due_answer;
   logic                req_taken = 1'b0;
   int unsigned         send_idle = 23;
   int unsigned         recv_idle = 76;
   int unsigned         results_seen = 0;
   int unsigned         hold_left = 0;
   logic                hold_done = 1'b0;
   int unsigned         error_count = 0;

   decision_tree_inference dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_node_slot       (req_node_slot),
      .req_leaf_mark       (req_leaf_mark),
      .req_split_feature   (req_split_feature),
      .req_split_threshold (req_split_threshold),
      .req_left_child      (req_left_child),
      .req_right_child     (req_right_child),
      .req_node_class      (req_node_class),
      .req_feature_slot    (req_feature_slot),
      .req_feature_value   (req_feature_value),
      .req_last_feature    (req_last_feature),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // walk the bench copy of the tree from node 0
   function automatic tree_answer_t walk_tree();
      int unsigned        limit;
      int unsigned        cur;
      link_type           lk;
      split_type          sp;
      logic [CHILD_W-1:0] nxt;
      // counts past the table size act as a full table
      limit = (node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg;
      if (limit == 0) return '{cls: '0, status: STATUS_EMPTY};
      cur = 0;
      repeat (MAX_STEPS) begin
         lk = tree_link[cur];
         sp = tree_split[cur];
         // leaf or any missing child ends the walk here
         if (lk.leaf || lk.left[CHILD_W-1] || lk.right[CHILD_W-1])
            return '{cls: lk.cls, status: STATUS_OK};
         // signed q16.16 compare, ties go left
         nxt = ($signed(sample_values[sp.feature]) <= $signed(sp.threshold)) ?
               lk.left : lk.right;
         // child past the loaded nodes also stops on the current node
         if (nxt >= limit) return '{cls: lk.cls, status: STATUS_OK};
         cur = nxt;
      end
      return '{cls: '0, status: STATUS_STEP_LIMIT};
   endfunction

   // update bench state for one accepted transaction
   function automatic void apply_request(tree_req_t it);
      if (it.kind == REQ_NODE_WRITE) begin
         tree_split[it.node_slot] = '{feature: it.split_feature,
                                      threshold: it.split_threshold};
         tree_link[it.node_slot] = '{leaf: it.leaf_mark, left: it.left_child,
                                     right: it.right_child, cls: it.node_class};
      end else begin
         sample_values[it.feature_slot] = it.feature_value;
         if (it.last_feature) answers_due.push_back(walk_tree());
      end
   endfunction

   // every field random, so unused fields toggle too
   function automatic tree_req_t noise_item();
      tree_req_t it;
      it.kind            = 1'($urandom_range(1));
      it.node_slot       = NODE_AW'($urandom());
      it.leaf_mark       = 1'($urandom_range(1));
      it.split_feature   = FEAT_AW'($urandom());
      it.split_threshold = $urandom();
      it.left_child      = CHILD_W'($urandom());
      it.right_child     = CHILD_W'($urandom());
      it.node_class      = CLASS_W'($urandom());
      it.feature_slot    = FEAT_AW'($urandom());
      it.feature_value   = $urandom();
      it.last_feature    = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic tree_req_t node_write(logic [NODE_AW-1:0] slot, logic leaf,
                                            logic [FEAT_AW-1:0] feat,
                                            logic [VALUE_W-1:0] thr,
                                            logic [CHILD_W-1:0] left,
                                            logic [CHILD_W-1:0] right,
                                            logic [CLASS_W-1:0] cls);
      tree_req_t it;
      it                 = noise_item();
      it.kind            = REQ_NODE_WRITE;
      it.node_slot       = slot;
      it.leaf_mark       = leaf;
      it.split_feature   = feat;
      it.split_threshold = thr;
      it.left_child      = left;
      it.right_child     = right;
      it.node_class      = cls;
      return it;
   endfunction

   function automatic tree_req_t feature_write(logic [FEAT_AW-1:0] slot,
                                               logic [VALUE_W-1:0] value, logic last);
      tree_req_t it;
      it               = noise_item();
      it.kind          = REQ_FEATURE_WRITE;
      it.feature_slot  = slot;
      it.feature_value = value;
      it.last_feature  = last;
      return it;
   endfunction

   // values biased to extremes and a narrow band around zero so ties happen
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return Q_MIN;
         1:       return Q_MAX;
         2, 3:    return VALUE_W'($urandom_range(8)) - VALUE_W'(4);
         default: return $urandom();
      endcase
   endfunction

   // mostly in-range children, some missing, some past the node count
   function automatic logic [CHILD_W-1:0] pick_child(int unsigned lim);
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return CHILD_NONE;
      if (r == 1) return CHILD_W'($urandom());
      if (r == 2 && lim < MAX_NODES) return CHILD_W'($urandom_range(MAX_NODES - 1, lim));
      return CHILD_W'($urandom_range(lim - 1));
   endfunction

   // one sample: a few node rewrites, some features, then the last feature, or at times one random transaction instead
   task automatic queue_sample(int unsigned lim);
      tree_req_t   it;
      int unsigned k;
      if ($urandom_range(9) == 0) begin
         pending_items.push_back(noise_item());
         return;
      end
      k = $urandom_range(5);
      repeat (k) begin
         it = node_write(NODE_AW'($urandom_range(lim - 1)), $urandom_range(5) == 0,
                         FEAT_AW'($urandom()), pick_value(), pick_child(lim),
                         pick_child(lim), CLASS_W'($urandom()));
         pending_items.push_back(it);
      end
      k = $urandom_range(6);
      repeat (k) pending_items.push_back(feature_write(FEAT_AW'($urandom()), pick_value(), 1'b0));
      pending_items.push_back(feature_write(FEAT_AW'($urandom()), pick_value(), 1'b1));
   endtask

   // register write, only called while the block is idle
   task automatic write_reg(logic idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_NODE_COUNT) node_count_cfg = value;
      else feature_count_cfg = FC_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for all transactions sent and answered, then let the walk settle
   task automatic wait_quiet();
      int unsigned waited;
      waited = 0;
      while (pending_items.size() != 0) @(posedge clock);
      while (answers_due.size() != 0 && waited < QUIET_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // note request acceptance at the rising edge
   always @(posedge clock) req_taken <= !reset && req_valid && req_ready;

   // request driver: retire the accepted transaction, then maybe offer the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) apply_request(pending_items.pop_front());
         // valid holds with its payload until taken
         if (!req_valid || req_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
               offer = pending_items[0];
               req_valid           <= 1'b1;
               req_type            <= offer.kind;
               req_node_slot       <= offer.node_slot;
               req_leaf_mark       <= offer.leaf_mark;
               req_split_feature   <= offer.split_feature;
               req_split_threshold <= offer.split_threshold;
               req_left_child      <= offer.left_child;
               req_right_child     <= offer.right_child;
               req_node_class      <= offer.node_class;
               req_feature_slot    <= offer.feature_slot;
               req_feature_value   <= offer.feature_value;
               req_last_feature    <= offer.last_feature;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response receiver: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen == HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // response monitor: compare against the oldest pending classification
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual class %0h status %0d",
                     $time, rsp_predicted_class, rsp_status);
            error_count++;
         end else begin
            due_answer = answers_due.pop_front();
            if (rsp_predicted_class !== due_answer.cls) begin
               $display("%0t: class mismatch, expected %0h, actual %0h",
                        $time, due_answer.cls, rsp_predicted_class);
               error_count++;
            end
            if (rsp_status !== due_answer.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, due_answer.status, rsp_status);
               error_count++;
            end
         end
         results_seen <= results_seen + 1;
      end
   end

   // stimulus sequence and end of run
   initial begin
      int unsigned nc_plan [PHASES];
      int unsigned fc_plan [PHASES];
      int unsigned lim;
      nc_plan = '{8, PRELOAD_NODES, 3, 64, 1, 16};
      fc_plan = '{64, 1, 33, 64, 7, 1};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty tree: no node table reads happen, so safe before any load
      write_reg(CSR_NODE_COUNT, '0);
      write_reg(CSR_FEATURE_COUNT, CSR_W'(MAX_FEATURES));
      pending_items.push_back(feature_write('0, Q_MIN, 1'b1));
      pending_items.push_back(feature_write('1, Q_MAX, 1'b0));

      // load every sample slot and the low node entries that the walks below reach
      for (int f = 0; f < MAX_FEATURES; f++)
         pending_items.push_back(feature_write(FEAT_AW'(f), pick_value(), 1'b0));
      for (int n = 0; n < PRELOAD_NODES; n++)
         pending_items.push_back(node_write(NODE_AW'(n), 1'($urandom_range(1)),
                                            FEAT_AW'($urandom()), $urandom(),
                                            CHILD_W'($urandom()), CHILD_W'($urandom()),
                                            CLASS_W'($urandom())));
      wait_quiet();

      // full table
      write_reg(CSR_NODE_COUNT, CSR_W'(MAX_NODES));
      // root is a leaf
      pending_items.push_back(node_write('0, 1'b1, '0, '0, CHILD_NONE, CHILD_NONE, 8'hA5));
      pending_items.push_back(feature_write(6'd5, 32'd1, 1'b1));
      // root splits on the top feature, equal value goes left
      pending_items.push_back(node_write(10'd1, 1'b1, '0, '0, '0, '0, 8'h11));
      pending_items.push_back(node_write(10'd2, 1'b1, '0, '0, '0, '0, 8'h22));
      pending_items.push_back(node_write('0, 1'b0, '1, Q_MAX, 11'd1, 11'd2, 8'h01));
      pending_items.push_back(feature_write('1, Q_MAX, 1'b1));
      // above the smallest threshold goes right
      pending_items.push_back(node_write('0, 1'b0, '1, Q_MIN, 11'd1, 11'd2, 8'h01));
      pending_items.push_back(feature_write('1, Q_MIN + 1, 1'b1));
      // missing left child stops on the root
      pending_items.push_back(node_write('0, 1'b0, '0, '0, CHILD_NONE, 11'd2, 8'hC3));
      pending_items.push_back(feature_write('0, '0, 1'b1));
      // self loop runs into the step limit
      pending_items.push_back(node_write('0, 1'b0, '0, '0, '0, '0, 8'h5A));
      pending_items.push_back(feature_write('0, '0, 1'b1));
      wait_quiet();

      // two nodes: right child past the count stops on the root
      write_reg(CSR_NODE_COUNT, CSR_W'(2));
      write_reg(CSR_FEATURE_COUNT, CSR_W'(1));
      pending_items.push_back(node_write('0, 1'b0, 6'd1, '0, 11'd1, 11'd1000, 8'h77));
      pending_items.push_back(feature_write(6'd1, 32'd1, 1'b1));
      pending_items.push_back(feature_write(6'd1, '1, 1'b1));
      wait_quiet();

      // count beyond the table size acts as a full table, top entry reachable
      write_reg(CSR_NODE_COUNT, '1);
      pending_items.push_back(node_write(10'd1023, 1'b1, '0, '0, CHILD_NONE, CHILD_NONE,
                                         8'h3C));
      pending_items.push_back(node_write('0, 1'b0, 6'd2, '0, 11'd1023, 11'd1023, 8'h00));
      pending_items.push_back(feature_write(6'd2, '0, 1'b1));

      // random samples over several register settings and idle mixes
      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         if (p < 2) begin
            send_idle = 23;
            recv_idle = 76;
         end else if (p < 4) begin
            send_idle = 76;
            recv_idle = 23;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_reg(CSR_NODE_COUNT, CSR_W'(nc_plan[p]));
         write_reg(CSR_FEATURE_COUNT, CSR_W'(fc_plan[p]));
         lim = (nc_plan[p] > MAX_NODES) ? MAX_NODES : nc_plan[p];
         while (pending_items.size() < ITEMS_PER_PHASE) queue_sample(lim);
      end

      wait_quiet();
      @(negedge clock);
      if (answers_due.size() != 0) begin
         $display("%0t: %0d results never arrived, next expected class %0h status %0d",
                  $time, answers_due.size(), answers_due[0].cls, answers_due[0].status);
         error_count++;
      end
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #12_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/dti_pkg.sv
rtl/core/dti_step.sv
rtl/core/decision_tree_inference.sv
test/decision_tree_inference_tb.sv
